// ===== hdl/ccr_pkg.sv =====
package ccr_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int KNOT_W         = 24;
  localparam int SC_W           = 10;
  localparam logic [SC_W-1:0] SC_RESET = 10'd100;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // Operations of the shared arithmetic unit.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } arith_cmd_t;

endpackage

// ===== hdl/closed_catmull_rom_sampler.sv =====
// Channel  Direction  Contents
// in_      slave      tdata {sample_index, point_y, point_x}, tuser mode
// out_     master     tdata {sample_y, sample_x}, tuser sample_valid
// cfg_     slave      data sample_count, always ready
//
// An append issues two multiplies and one square root of 24 steps on the shared unit for each
// chord length, two chords for a point after the first and one for the first. A clear only
// resets the point count. A sample needs two divides of 48 steps, eleven multiplies of 24
// steps and a knot search that reads one knot at a time, all through the one shared
// arithmetic unit and a single read port per memory.
// Reset is synchronous and active low; the memories need no clearing pass.
// The input is not ready while an item is in work; a finished sample waits in
// the output register and holds the sequencer only if a second one completes.
module closed_catmull_rom_sampler #(
  parameter int MAX_POINTS = ccr_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // point_x[15:0], point_y[31:16], sample_index[41:32]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // sample_x[15:0], sample_y[31:16]
  output logic [0:0]  out_tuser,  // sample_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ccr_pkg::SC_W-1:0] cfg_data
);
  import ccr_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int KW = $clog2(MAX_POINTS + 1);

  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] A_RD   = 6'd1;   // read neighbor point and knot
  localparam logic [5:0] A_LD   = 6'd2;
  localparam logic [5:0] C_MX   = 6'd3;   // chord: dx squared
  localparam logic [5:0] C_MXW  = 6'd4;
  localparam logic [5:0] C_MY   = 6'd5;   // chord: dy squared
  localparam logic [5:0] C_MYW  = 6'd6;
  localparam logic [5:0] C_SQ   = 6'd7;   // chord: square root
  localparam logic [5:0] C_SQW  = 6'd8;
  localparam logic [5:0] S_RD   = 6'd9;   // read total length
  localparam logic [5:0] S_CK   = 6'd10;
  localparam logic [5:0] S_MW   = 6'd11;  // k * total
  localparam logic [5:0] S_DV   = 6'd12;  // divide by sample_count
  localparam logic [5:0] S_DVW  = 6'd13;
  localparam logic [5:0] S_SA   = 6'd14;  // knot search
  localparam logic [5:0] S_SC   = 6'd15;
  localparam logic [5:0] S_HD   = 6'd16;  // segment fraction
  localparam logic [5:0] S_HDW  = 6'd17;
  localparam logic [5:0] P_R0   = 6'd18;  // fetch four control points
  localparam logic [5:0] P_R1   = 6'd19;
  localparam logic [5:0] P_R2   = 6'd20;
  localparam logic [5:0] P_R3   = 6'd21;
  localparam logic [5:0] P_L    = 6'd22;
  localparam logic [5:0] H_Q0   = 6'd23;  // tangent terms scaled by span
  localparam logic [5:0] H_Q0W  = 6'd24;
  localparam logic [5:0] H_Q1   = 6'd25;
  localparam logic [5:0] H_Q1W  = 6'd26;
  localparam logic [5:0] H_C    = 6'd27;  // coefficients
  localparam logic [5:0] H_M    = 6'd28;  // Horner step
  localparam logic [5:0] H_MW   = 6'd29;
  localparam logic [5:0] H_R    = 6'd30;  // round and saturate
  localparam logic [5:0] S_FIN  = 6'd31;

  logic [5:0]        state_r, state_nxt;
  logic [15:0]       px_r, py_r, ox_r, oy_r;
  logic [9:0]        k_r;
  logic [SC_W-1:0]   sc_r;
  logic [KW-1:0]     cnt_r, j_r;
  logic              ph_r, crd_r, rvalid_r;
  logic [KNOT_W-1:0] base_r, total_r, t_r, lo_r, hi_r, s_r;
  logic [33:0]       sq_r;
  logic [IW-1:0]     i_r;
  logic [31:0]       pm_r, p0_r, p1_r, p2_r;
  logic [47:0]       q0_r, q1_r, c0_r, c2_r, r_r;
  logic [1:0]        hs_r;
  logic [15:0]       sx_r, sy_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;
  logic              out_flag_r;

  arith_cmd_t        cmd;
  logic [47:0]       opa;
  logic [23:0]       opb;
  logic              ar_done;
  logic [71:0]       ar_res;

  logic              pt_we, kn_we;
  logic [IW-1:0]     pt_raddr;
  logic [KW-1:0]     kn_raddr, kn_waddr;
  logic [31:0]       pt_rdata;
  logic [KNOT_W-1:0] kn_rdata, kn_wdata;

  logic              in_fire, cfg_fire, out_free, full;
  logic [16:0]       adx, ady;
  logic signed [16:0] dx, dy;
  logic [24:0]       ksum;
  logic [KNOT_W-1:0] ksat, span;
  logic [KW-1:0]     i_ext, jn, j2n;
  logic [IW-1:0]     im_idx, j_idx, j2_idx;
  logic signed [15:0] pms, p0s, p1s, p2s;
  logic signed [47:0] pme, p0e, p1e, p2e, d0e, d1e, dpe, c3e, addend, hnext, rnd;
  logic signed [32:0] vq;
  logic [15:0]       vsat;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (cnt_r == KW'(MAX_POINTS));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

  // Chord length of the appended point to the neighbor held in ox/oy.
  assign dx   = $signed({px_r[15], px_r}) - $signed({ox_r[15], ox_r});
  assign dy   = $signed({py_r[15], py_r}) - $signed({oy_r[15], oy_r});
  assign adx  = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady  = dy[16] ? 17'(-dy) : 17'(dy);
  assign ksum = {1'b0, base_r} + {7'd0, ar_res[17:0]};
  assign ksat = ksum[24] ? {KNOT_W{1'b1}} : ksum[KNOT_W-1:0];
  assign span = hi_r - lo_r;

  // Neighbor indices wrapped round the loop.
  assign i_ext  = KW'(i_r);
  assign jn     = (i_ext + KW'(1) == cnt_r) ? KW'(0) : i_ext + KW'(1);
  assign j2n    = (jn + KW'(1) == cnt_r) ? KW'(0) : jn + KW'(1);
  assign im_idx = (i_r == IW'(0)) ? IW'(cnt_r - KW'(1)) : i_r - IW'(1);
  assign j_idx  = jn[IW-1:0];
  assign j2_idx = j2n[IW-1:0];

  // Coordinate under evaluation: x first, then y.
  assign pms = crd_r ? $signed(pm_r[31:16]) : $signed(pm_r[15:0]);
  assign p0s = crd_r ? $signed(p0_r[31:16]) : $signed(p0_r[15:0]);
  assign p1s = crd_r ? $signed(p1_r[31:16]) : $signed(p1_r[15:0]);
  assign p2s = crd_r ? $signed(p2_r[31:16]) : $signed(p2_r[15:0]);
  assign pme = {{32{pms[15]}}, pms};
  assign p0e = {{32{p0s[15]}}, p0s};
  assign p1e = {{32{p1s[15]}}, p1s};
  assign p2e = {{32{p2s[15]}}, p2s};
  assign d0e = p1e - pme;
  assign d1e = p2e - p0e;
  assign dpe = p1e - p0e;
  assign c3e = ((p0e - p1e) <<< 16) + $signed(q0_r) + $signed(q1_r);

  always_comb begin
    unique case (hs_r)
      2'd0:    addend = $signed(c2_r);
      2'd1:    addend = $signed(q0_r);
      default: addend = $signed(c0_r);
    endcase
  end
  // The product's bits above 2^24 are the product shifted down, rounded to minus infinity.
  assign hnext = $signed(ar_res[71:24]) + addend;
  assign rnd   = $signed(r_r) + 48'sd16384;
  assign vq    = rnd[47:15];
  always_comb begin
    if (vq > 33'sd32767) begin
      vsat = 16'h7FFF;
    end else if (vq < -33'sd32768) begin
      vsat = 16'h8000;
    end else begin
      vsat = vq[15:0];
    end
  end

  // Sequencer: next state, shared unit commands and memory addresses.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    opa       = '0;
    opb       = '0;
    pt_raddr  = '0;
    kn_raddr  = '0;
    pt_we     = 1'b0;
    kn_we     = 1'b0;
    kn_waddr  = ph_r ? cnt_r + KW'(1) : cnt_r;
    kn_wdata  = ksat;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          priority if (in_tuser == MODE_APPEND) begin
            if (!full) begin
              pt_we     = 1'b1;
              state_nxt = A_RD;
            end
          end else if (in_tuser == MODE_SAMPLE) begin
            state_nxt = S_RD;
          end
        end
      end
      A_RD: begin
        pt_raddr  = ph_r ? IW'(0) : IW'(cnt_r - KW'(1));
        kn_raddr  = cnt_r - KW'(1);
        state_nxt = A_LD;
      end
      A_LD: state_nxt = C_MX;
      C_MX: begin
        cmd       = '{start: 1'b1, op: OP_MUL};
        opa       = {31'd0, adx};
        opb       = {7'd0, adx};
        state_nxt = C_MXW;
      end
      C_MXW: if (ar_done) state_nxt = C_MY;
      C_MY: begin
        cmd       = '{start: 1'b1, op: OP_MUL};
        opa       = {31'd0, ady};
        opb       = {7'd0, ady};
        state_nxt = C_MYW;
      end
      C_MYW: if (ar_done) state_nxt = C_SQ;
      C_SQ: begin
        cmd       = '{start: 1'b1, op: OP_SQRT};
        opa       = {14'd0, sq_r};
        state_nxt = C_SQW;
      end
      C_SQW: begin
        if (ar_done) begin
          kn_we     = 1'b1;
          state_nxt = ph_r ? S_IDLE : A_RD;
        end
      end
      S_RD: begin
        kn_raddr  = cnt_r;
        state_nxt = S_CK;
      end
      S_CK: begin
        if (cnt_r == KW'(0) || k_r >= sc_r || kn_rdata == '0) begin
          state_nxt = S_FIN;
        end else begin
          cmd       = '{start: 1'b1, op: OP_MUL};
          opa       = {24'd0, kn_rdata};
          opb       = {14'd0, k_r};
          state_nxt = S_MW;
        end
      end
      S_MW: if (ar_done) state_nxt = S_DV;
      S_DV: begin
        cmd       = '{start: 1'b1, op: OP_DIV};
        opa       = ar_res[47:0];
        opb       = {14'd0, sc_r};
        state_nxt = S_DVW;
      end
      S_DVW: begin
        if (ar_done) begin
          state_nxt = (ar_res[47:0] >= {24'd0, total_r}) ? S_FIN : S_SA;
        end
      end
      S_SA: begin
        kn_raddr  = j_r;
        state_nxt = S_SC;
      end
      S_SC: begin
        priority if (t_r < kn_rdata) begin
          state_nxt = S_HD;
        end else if (j_r == cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SA;
        end
      end
      S_HD: begin
        cmd       = '{start: 1'b1, op: OP_DIV};
        opa       = {t_r - lo_r, 24'd0};
        opb       = span;
        state_nxt = S_HDW;
      end
      S_HDW: if (ar_done) state_nxt = P_R0;
      P_R0: begin
        pt_raddr  = im_idx;
        state_nxt = P_R1;
      end
      P_R1: begin
        pt_raddr  = i_r;
        state_nxt = P_R2;
      end
      P_R2: begin
        pt_raddr  = j_idx;
        state_nxt = P_R3;
      end
      P_R3: begin
        pt_raddr  = j2_idx;
        state_nxt = P_L;
      end
      P_L: state_nxt = H_Q0;
      H_Q0: begin
        cmd       = '{start: 1'b1, op: OP_MUL};
        opa       = d0e;
        opb       = span;
        state_nxt = H_Q0W;
      end
      H_Q0W: if (ar_done) state_nxt = H_Q1;
      H_Q1: begin
        cmd       = '{start: 1'b1, op: OP_MUL};
        opa       = d1e;
        opb       = span;
        state_nxt = H_Q1W;
      end
      H_Q1W: if (ar_done) state_nxt = H_C;
      H_C: state_nxt = H_M;
      H_M: begin
        cmd       = '{start: 1'b1, op: OP_MUL};
        opa       = r_r;
        opb       = s_r;
        state_nxt = H_MW;
      end
      H_MW: begin
        if (ar_done) begin
          state_nxt = (hs_r == 2'd2) ? H_R : H_M;
        end
      end
      H_R: state_nxt = crd_r ? S_FIN : H_Q0;
      S_FIN: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sc_r        <= SC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        sc_r <= cfg_data;
      end
      if (in_fire && in_tuser == MODE_CLEAR) begin
        cnt_r <= '0;
      end
      if (state_r == C_SQW && ar_done && ph_r) begin
        cnt_r <= cnt_r + KW'(1);
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        px_r     <= in_tdata[15:0];
        py_r     <= in_tdata[31:16];
        k_r      <= in_tdata[41:32];
        rvalid_r <= 1'b0;
        ph_r     <= (cnt_r == KW'(0));
        base_r   <= '0;
      end
      A_LD: begin
        ox_r <= pt_rdata[15:0];
        oy_r <= pt_rdata[31:16];
        if (!ph_r) begin
          base_r <= kn_rdata;
        end
      end
      C_MXW: if (ar_done) sq_r <= ar_res[33:0];
      C_MYW: if (ar_done) sq_r <= sq_r + ar_res[33:0];
      C_SQW: begin
        if (ar_done) begin
          base_r <= ksat;
          ph_r   <= 1'b1;
        end
      end
      S_CK: total_r <= kn_rdata;
      S_DVW: begin
        t_r  <= ar_res[KNOT_W-1:0];
        j_r  <= KW'(1);
        lo_r <= '0;
      end
      S_SC: begin
        if (t_r < kn_rdata) begin
          hi_r <= kn_rdata;
          i_r  <= IW'(j_r - KW'(1));
        end else begin
          lo_r <= kn_rdata;
          j_r  <= j_r + KW'(1);
        end
      end
      S_HDW: s_r <= ar_res[KNOT_W-1:0];
      P_R1: pm_r <= pt_rdata;
      P_R2: p0_r <= pt_rdata;
      P_R3: p1_r <= pt_rdata;
      P_L: begin
        p2_r  <= pt_rdata;
        crd_r <= 1'b0;
      end
      H_Q0W: if (ar_done) q0_r <= ar_res[47:0];
      H_Q1W: if (ar_done) q1_r <= ar_res[47:0];
      H_C: begin
        c0_r <= p0e <<< 15;
        c2_r <= (((dpe <<< 1) + dpe) <<< 15) - (($signed(q0_r) <<< 1) + $signed(q1_r));
        r_r  <= c3e;
        hs_r <= 2'd0;
      end
      H_MW: begin
        if (ar_done) begin
          r_r  <= hnext;
          hs_r <= hs_r + 2'd1;
        end
      end
      H_R: begin
        if (crd_r) begin
          sy_r     <= vsat;
          rvalid_r <= 1'b1;
        end else begin
          sx_r <= vsat;
        end
        crd_r <= 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          out_data_r <= rvalid_r ? {sy_r, sx_r} : 32'd0;
          out_flag_r <= rvalid_r;
        end
      end
      default: ;
    endcase
  end

  ccr_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .opa   (opa),
    .opb   (opb),
    .done  (ar_done),
    .res   (ar_res)
  );

  ccr_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk      (clk),
    .pt_we    (pt_we),
    .pt_waddr (cnt_r[IW-1:0]),
    .pt_wdata (in_tdata[31:0]),
    .pt_raddr (pt_raddr),
    .pt_rdata (pt_rdata),
    .kn_we    (kn_we),
    .kn_waddr (kn_waddr),
    .kn_wdata (kn_wdata),
    .kn_raddr (kn_raddr),
    .kn_rdata (kn_rdata)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HD |-> hi_r > lo_r)
    else $error("segment span is zero at the fraction divide");

  a_append_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == MODE_APPEND && !full |=> state_r == A_RD)
    else $error("append did not start the chord sequence");

  a_sample_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && rvalid_r |-> t_r < total_r)
    else $error("valid sample outside the loop length");
`endif

endmodule

// ===== hdl/ccr_arith.sv =====
module ccr_arith (
  input  logic               clk,
  input  logic               rst_n,
  input  ccr_pkg::arith_cmd_t cmd,
  input  logic [47:0]        opa,
  input  logic [23:0]        opb,
  output logic               done,
  output logic [71:0]        res
);
  import ccr_pkg::*;

  // One step per cycle: shift-add multiply (opa signed times opb unsigned),
  // restoring divide (opa / opb), and digit-by-digit square root of opa.
  localparam logic [5:0] MUL_LAST  = 6'd23;
  localparam logic [5:0] DIV_LAST  = 6'd47;
  localparam logic [5:0] SQRT_LAST = 6'd23;

  logic        busy_r, done_r;
  logic [1:0]  op_r;
  logic [5:0]  cnt_r;
  logic [71:0] acc_r, sh_r;
  logic [23:0] b_r;
  logic [26:0] rem_r;

  logic [24:0] div_tr;
  logic        div_ge;
  logic [26:0] sq_rem, sq_trial;
  logic        sq_ge;

  assign div_tr   = {rem_r[23:0], sh_r[47]};
  assign div_ge   = div_tr >= {1'b0, b_r};
  assign sq_rem   = {rem_r[24:0], sh_r[47:46]};
  assign sq_trial = {1'b0, acc_r[23:0], 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      acc_r <= '0;
      b_r   <= opb;
      rem_r <= '0;
      if (cmd.op == OP_MUL) begin
        sh_r <= {{24{opa[47]}}, opa};
      end else begin
        sh_r <= {24'd0, opa};
      end
      unique case (cmd.op)
        OP_MUL:  cnt_r <= MUL_LAST;
        OP_DIV:  cnt_r <= DIV_LAST;
        OP_SQRT: cnt_r <= SQRT_LAST;
        default: cnt_r <= 6'd0;
      endcase
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      unique case (op_r)
        OP_MUL: begin
          if (b_r[0]) begin
            acc_r <= acc_r + sh_r;
          end
          sh_r <= {sh_r[70:0], 1'b0};
          b_r  <= {1'b0, b_r[23:1]};
        end
        OP_DIV: begin
          rem_r <= {2'd0, div_ge ? (div_tr - {1'b0, b_r}) : div_tr};
          sh_r  <= {24'd0, sh_r[46:0], div_ge};
        end
        OP_SQRT: begin
          rem_r <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
          acc_r <= {48'd0, acc_r[22:0], sq_ge};
          sh_r  <= {sh_r[69:0], 2'b00};
        end
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign res  = (op_r == OP_DIV) ? sh_r : acc_r;

endmodule

// ===== hdl/ccr_store.sv =====
module ccr_store #(
  parameter int MAX_POINTS = ccr_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              pt_we,
  input  logic [$clog2(MAX_POINTS)-1:0]     pt_waddr,
  input  logic [31:0]                       pt_wdata,
  input  logic [$clog2(MAX_POINTS)-1:0]     pt_raddr,
  output logic [31:0]                       pt_rdata,
  input  logic                              kn_we,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   kn_waddr,
  input  logic [ccr_pkg::KNOT_W-1:0]        kn_wdata,
  input  logic [$clog2(MAX_POINTS+1)-1:0]   kn_raddr,
  output logic [ccr_pkg::KNOT_W-1:0]        kn_rdata
);
  import ccr_pkg::*;

  localparam int KW = $clog2(MAX_POINTS + 1);

  // Points are kept as {y, x}. The first knot is always zero and is not stored.
  logic [31:0]       pt_mem [MAX_POINTS];
  logic [KNOT_W-1:0] kn_mem [MAX_POINTS+1];
  logic [KNOT_W-1:0] kn_q_r;
  logic              kn_zero_r;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (kn_we) begin
      kn_mem[kn_waddr] <= kn_wdata;
    end
    kn_q_r    <= kn_mem[kn_raddr];
    kn_zero_r <= (kn_raddr == KW'(0));
  end

  assign kn_rdata = kn_zero_r ? '0 : kn_q_r;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ccr_pkg::*;

  localparam int LOOP_MAX = 64;
  localparam int KNOT_LIMIT = 24'hFFFFFF;
  // Append produces no result, so settle before a config write.
  localparam int SETTLE_CYCLES = 500;
  localparam int TOTAL_ITEMS = 1700;
  localparam int CALM_ITEMS = 1500;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // point_x[15:0], point_y[31:16], sample_index[41:32]
  logic [1:0]  in_tuser;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // sample_x[15:0], sample_y[31:16]
  logic [0:0]  out_tuser;  // sample_valid[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [SC_W-1:0] cfg_data;

  closed_catmull_rom_sampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // One curve sample as it appears on the result channel.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               ok;
  } curve_sample_t;

  // Shadow copy of the loop: points, cumulative chord-length knots, count.
  longint        loop_x [LOOP_MAX];
  longint        loop_y [LOOP_MAX];
  longint        knots  [LOOP_MAX+1];
  int            loop_len;
  int            samples_per_loop;

  curve_sample_t pending_samples[$];
  int            error_count;
  int            samples_seen;
  int            valid_seen;
  int            items_sent;
  int            loops_filled;
  bit            calm;           // no idling in the closing stretch

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint int_sqrt(input longint v);
    longint root;
    longint bit_val;
    root = 0;
    bit_val = 64'sd1 <<< 62;
    while (bit_val > v) bit_val = bit_val >>> 2;
    while (bit_val != 0) begin
      if (v >= root + bit_val) begin
        v = v - (root + bit_val);
        root = (root >>> 1) + bit_val;
      end else begin
        root = root >>> 1;
      end
      bit_val = bit_val >>> 2;
    end
    return root;
  endfunction

  function automatic longint chord_len(input int a, input int b);
    longint dx;
    longint dy;
    dx = loop_x[b] - loop_x[a];
    dy = loop_y[b] - loop_y[a];
    return int_sqrt(dx * dx + dy * dy);
  endfunction

  function automatic longint knot_sum(input longint k, input longint len);
    return (k + len > KNOT_LIMIT) ? KNOT_LIMIT : k + len;
  endfunction

  // Hermite segment from p0 to p1 with neighbours pm and p2; s is Q0.24.
  // The arithmetic shift right is the floor division that the block uses.
  function automatic logic signed [15:0] hermite_axis(input longint pm, input longint p0,
                                                      input longint p1, input longint p2,
                                                      input longint h, input longint s);
    longint q0, q1, c0, c2, c3, r, v;
    q0 = h * (p1 - pm);
    q1 = h * (p2 - p0);
    c0 = p0 * 32768;
    c2 = 3 * (p1 - p0) * 32768 - (2 * q0 + q1);
    c3 = 2 * (p0 - p1) * 32768 + q0 + q1;
    r = c3;
    r = ((r * s) >>> 24) + c2;
    r = ((r * s) >>> 24) + q0;
    r = ((r * s) >>> 24) + c0;
    v = (r + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void add_point(input logic signed [15:0] px, input logic signed [15:0] py);
    int n;
    n = loop_len;
    if (n < LOOP_MAX) begin
      loop_x[n] = longint'(px);
      loop_y[n] = longint'(py);
      knots[0] = 0;
      if (n > 0) knots[n] = knot_sum(knots[n-1], chord_len(n-1, n));
      knots[n+1] = knot_sum(knots[n], chord_len(n, 0));
      loop_len = n + 1;
    end
  endfunction

  function automatic curve_sample_t sample_curve(input int k);
    curve_sample_t res;
    longint total, t, h, s;
    int n, i, j, jm, j2;
    res = '0;
    n = loop_len;
    if (n > 0 && k < samples_per_loop && knots[n] != 0) begin
      total = knots[n];
      t = (longint'(k) * total) / samples_per_loop;
      if (t < total) begin
        for (i = 0; i < n; i++)
          if (knots[i] <= t && t < knots[i+1]) break;
        if (i < n) begin
          j = (i + 1) % n;
          jm = (i + n - 1) % n;
          j2 = (j + 1) % n;
          h = knots[i+1] - knots[i];
          s = ((t - knots[i]) <<< 24) / h;
          res.x = hermite_axis(loop_x[jm], loop_x[i], loop_x[j], loop_x[j2], h, s);
          res.y = hermite_axis(loop_y[jm], loop_y[i], loop_y[j], loop_y[j2], h, s);
          res.ok = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Updates the shadow loop for one accepted transfer; returns 1 if a sample follows.
  function automatic bit track_item(input logic [1:0] mode, input logic signed [15:0] px,
                                    input logic signed [15:0] py, input int k,
                                    output curve_sample_t res);
    res = '0;
    case (mode)
      MODE_APPEND: add_point(px, py);
      MODE_CLEAR: begin
        loop_len = 0;
        knots[0] = 0;
      end
      MODE_SAMPLE: begin
        res = sample_curve(k);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk);
  endtask

  // Offers one item and waits for its transfer. A random gap may follow.
  // When a typed expectation is given it replaces the predicted one.
  task automatic send_item(input logic [1:0] mode, input logic signed [15:0] px,
                           input logic signed [15:0] py, input logic [9:0] k,
                           input bit typed = 0, input curve_sample_t typed_res = '0);
    curve_sample_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {6'd0, k, py, px};
    do @(posedge clk); while (!in_tready);
    if (track_item(mode, px, py, int'(k), res))
      pending_samples.insert(pending_samples.size(), typed ? typed_res : res);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      idle_cycles($urandom_range(1, 14));
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    idle_cycles(SETTLE_CYCLES);
  endtask

  task automatic write_sample_count(input logic [SC_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    samples_per_loop = int'(value);
  endtask

  // Result side: random stall bursts until the closing stretch.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      idle_cycles($urandom_range(1, 30));
      if (!calm) begin
        out_tready <= 1'b0;
        idle_cycles($urandom_range(1, 14));
      end
    end
  end

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    curve_sample_t want;
    curve_sample_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tuser[0]};
      samples_seen++;
      if (got.ok) valid_seen++;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample x=%0d y=%0d valid=%0b", $time, got.x, got.y, got.ok);
        error_count++;
      end else begin
        want = pending_samples.pop_front();
        if (got.x !== want.x)
          $display("%0t: sample_x expected %0d actual %0d", $time, want.x, got.x);
        if (got.y !== want.y)
          $display("%0t: sample_y expected %0d actual %0d", $time, want.y, got.y);
        if (got.ok !== want.ok)
          $display("%0t: sample_valid expected %0b actual %0b", $time, want.ok, got.ok);
        if (got !== want) error_count++;
      end
    end
  end

  // Directed rows: mode, x, y, k, whether the result is typed here, and that result.
  typedef struct {
    logic [1:0]    mode;
    int            px;
    int            py;
    int            k;
    bit            typed;
    curve_sample_t res;
  } stim_row_t;

  localparam curve_sample_t NO_SAMPLE = '0;

  stim_row_t directed[] = '{
    '{MODE_SAMPLE, 0, 0, 0, 1, NO_SAMPLE},             // empty loop
    '{MODE_APPEND, 100, -200, 0, 0, NO_SAMPLE},
    '{MODE_SAMPLE, 0, 0, 5, 1, NO_SAMPLE},             // single point, zero length
    '{MODE_APPEND, 100, -200, 0, 0, NO_SAMPLE},
    '{MODE_SAMPLE, 0, 0, 0, 1, NO_SAMPLE},             // two equal points, still zero
    '{MODE_CLEAR, 0, 0, 0, 0, NO_SAMPLE},
    '{MODE_APPEND, -32768, -32768, 0, 0, NO_SAMPLE},
    '{MODE_APPEND, 32767, 32767, 0, 0, NO_SAMPLE},
    '{MODE_APPEND, 32767, -32768, 0, 0, NO_SAMPLE},
    '{MODE_APPEND, -32768, 32767, 0, 0, NO_SAMPLE},
    '{MODE_SAMPLE, 0, 0, 0, 0, NO_SAMPLE},
    '{MODE_SAMPLE, 0, 0, 13, 0, NO_SAMPLE},
    '{MODE_SAMPLE, 0, 0, 99, 0, NO_SAMPLE},            // last sample of the loop
    '{MODE_SAMPLE, 0, 0, 100, 1, NO_SAMPLE},           // index at the count
    '{MODE_SAMPLE, 0, 0, 1023, 1, NO_SAMPLE},          // largest index
    '{2'd3, 1234, 4321, 7, 0, NO_SAMPLE},              // unused mode, ignored
    '{MODE_CLEAR, 0, 0, 0, 0, NO_SAMPLE},
    '{MODE_SAMPLE, 0, 0, 0, 1, NO_SAMPLE},             // cleared loop
    '{MODE_APPEND, 0, 0, 0, 0, NO_SAMPLE},
    '{MODE_APPEND, 16384, 0, 0, 0, NO_SAMPLE},
    '{MODE_APPEND, 0, 16384, 0, 0, NO_SAMPLE},
    '{MODE_SAMPLE, 0, 0, 50, 0, NO_SAMPLE}
  };

  function automatic logic signed [15:0] rand_coord;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);                         // full range, saturates often
      1: return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
      default: return $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
    endcase
  endfunction

  task automatic random_loop;
    int pts;
    int reqs;
    logic [9:0] k;
    pts = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
    if (pts > LOOP_MAX) loops_filled++;
    send_item(MODE_CLEAR, 16'($urandom), 16'($urandom), 10'($urandom));
    for (int p = 0; p < pts; p++) begin
      // a repeated point now and then gives zero-length chords
      if (p > 0 && $urandom_range(0, 15) == 0)
        send_item(MODE_APPEND, 16'(loop_x[(loop_len - 1) % LOOP_MAX]),
                  16'(loop_y[(loop_len - 1) % LOOP_MAX]), 10'($urandom));
      else
        send_item(MODE_APPEND, rand_coord(), rand_coord(), 10'($urandom));
    end
    reqs = $urandom_range(3, 20);
    for (int r = 0; r < reqs; r++) begin
      k = (samples_per_loop > 0 && $urandom_range(0, 7) != 0)
          ? 10'($urandom_range(0, samples_per_loop - 1)) : 10'($urandom);
      case ($urandom_range(0, 19))
        0: send_item(2'd3, 16'($urandom), 16'($urandom), 10'($urandom));
        1: send_item(MODE_APPEND, rand_coord(), rand_coord(), 10'($urandom));
        default: send_item(MODE_SAMPLE, 16'($urandom), 16'($urandom), k);
      endcase
    end
  endtask

  initial begin
    int phase;
    bit paused;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_APPEND;
    cfg_valid = 1'b0;
    cfg_data = '0;
    error_count = 0;
    samples_seen = 0;
    valid_seen = 0;
    items_sent = 0;
    loops_filled = 0;
    calm = 1'b0;
    paused = 1'b0;
    loop_len = 0;
    samples_per_loop = int'(SC_RESET);
    foreach (knots[i]) knots[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].mode, 16'(directed[i].px), 16'(directed[i].py),
                10'(directed[i].k), directed[i].typed, directed[i].res);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= 120 * phase + 30) begin
        case (phase % 6)
          0: write_sample_count(10'd1);
          1: write_sample_count(10'd1023);
          2: write_sample_count(10'd0);
          3: write_sample_count(SC_RESET);
          default: write_sample_count(10'($urandom_range(1, 1023)));
        endcase
        phase++;
      end
      if (!paused && items_sent > TOTAL_ITEMS / 2) begin
        // hold the input until the block has delivered everything it owes
        in_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      if (items_sent >= CALM_ITEMS) calm = 1'b1;
      random_loop();
    end
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    idle_cycles(SETTLE_CYCLES);

    $display("Run covered %0d input items, %0d samples (%0d valid), %0d overfilled loops,",
             items_sent, samples_seen, valid_seen, loops_filled);
    $display("and sample counts of 0, 1, 100, 1023 and random values.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A run that outlasts this bound is reported as a failure.
  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
